// ===== rtl/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and constants of the median string search unit: payload
// structs, register map, reset values and the scorer step flags.
// ----------------------------------------------------------------------------
package mss_pkg;

    typedef struct packed {
        logic [1:0] base;
        logic       last;
    } in_t;

    typedef struct packed {
        logic [15:0] motif;
        logic [7:0]  best_distance;
    } out_t;

    // Flags that travel with each base read during the search.
    typedef struct packed {
        logic win_ok;    // a full window ends at this base
        logic seq_end;   // last base of a sequence
        logic cand_end;  // last base of the data set for this candidate
        logic final_c;   // this candidate is the last one
    } step_flags_t;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_NUM_SEQS  = 2'd0;
    localparam logic [1:0] REG_SEQ_LEN   = 2'd1;
    localparam logic [1:0] REG_MOTIF_LEN = 2'd2;

    localparam logic [4:0] NUM_SEQS_RST  = 5'd4;
    localparam logic [8:0] SEQ_LEN_RST   = 9'd57;
    localparam logic [3:0] MOTIF_LEN_RST = 4'd3;

    localparam logic [7:0] DIST_SAT = 8'hFF;

endpackage

// ===== rtl/median_string_search_unit.sv =====
// ----------------------------------------------------------------------------
// median_string_search_unit
// Loads a DNA data set base by base, then scores every candidate motif
// against it and returns the first motif with the lowest total distance.
// ----------------------------------------------------------------------------
//  Channel   Direction   Handshake              Payload
//  s_        in          s_valid / s_ready      mss_pkg::in_t  (base, last)
//  m_        out         m_valid / m_ready      mss_pkg::out_t (motif, best_distance)
//  APB       in          psel/penable/pready    num_seqs, seq_len, motif_len
//
// Loading takes one item per cycle. After the last item the search reads the
// base store once per candidate through its single read port, one base per
// cycle, for each of the 4^L candidates over T * N bases, with L, T, N the
// effective motif length, sequence count and sequence length. No item is taken meanwhile.
// Reset is synchronous and returns the control state and the registers to
// their reset values.
// A held result does not stop the next data set from loading.
// ----------------------------------------------------------------------------
module median_string_search_unit #(
    parameter int MAX_SEQS  = 16,
    parameter int MAX_LEN   = 256,
    parameter int MAX_MOTIF = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  mss_pkg::in_t                   s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output mss_pkg::out_t                  m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mss_pkg::PADDR_W-1:0]    paddr,
    input  logic [mss_pkg::PDATA_W-1:0]    pwdata,
    output logic [mss_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    import mss_pkg::*;

    localparam int DEPTH = MAX_SEQS * MAX_LEN;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(MAX_SEQS + 1);
    localparam int NW    = $clog2(MAX_LEN + 1);
    localparam int LW    = $clog2(MAX_MOTIF + 1);
    localparam int CW    = TW + NW;
    localparam int PW    = 2 * MAX_MOTIF;
    localparam int SW    = $clog2(MAX_SEQS * MAX_MOTIF + 1);

    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_PACK   = 5'b01000,
        ST_IDLE2  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;

    logic [4:0]      num_seqs_reg;
    logic [8:0]      seq_len_reg;
    logic [3:0]      motif_len_reg;

    logic [TW-1:0]   t_eff;
    logic [NW-1:0]   n_eff;
    logic [LW-1:0]   l_clamp;
    logic [LW-1:0]   l_eff;
    logic [CW-1:0]   cap;
    logic [PW-1:0]   cand_mask;

    logic [CW-1:0]   load_cnt_reg, load_cnt_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [NW-1:0]   pos_reg, pos_next;
    logic [PW-1:0]   cand_reg, cand_next;

    logic            have_reg;
    logic [SW-1:0]   best_score_reg;
    logic [PW-1:0]   best_motif_reg;

    logic            s_fire;
    logic            cfg_wr;
    logic [1:0]      cfg_idx;
    logic            ram_we;
    logic [1:0]      ram_rdata;

    logic            issue_valid;
    step_flags_t     issue_flags;
    logic            res_valid;
    logic            res_final;
    logic [SW-1:0]   res_score;
    logic [PW-1:0]   res_cand;

    logic [PW+15:0]  packed_motif;
    logic [7:0]      dist_sat;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_seqs_reg  <= NUM_SEQS_RST;
            seq_len_reg   <= SEQ_LEN_RST;
            motif_len_reg <= MOTIF_LEN_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_NUM_SEQS:  num_seqs_reg  <= pwdata[4:0];
                REG_SEQ_LEN:   seq_len_reg   <= pwdata[8:0];
                REG_MOTIF_LEN: motif_len_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_NUM_SEQS:  prdata = PDATA_W'(num_seqs_reg);
            REG_SEQ_LEN:   prdata = PDATA_W'(seq_len_reg);
            REG_MOTIF_LEN: prdata = PDATA_W'(motif_len_reg);
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective sizes, clamped into the supported ranges
    // ------------------------------------------------------------------
    always_comb begin
        if (num_seqs_reg == '0) begin
            t_eff = TW'(1);
        end else if (32'(num_seqs_reg) > MAX_SEQS) begin
            t_eff = TW'(MAX_SEQS);
        end else begin
            t_eff = TW'(num_seqs_reg);
        end

        if (seq_len_reg == '0) begin
            n_eff = NW'(1);
        end else if (32'(seq_len_reg) > MAX_LEN) begin
            n_eff = NW'(MAX_LEN);
        end else begin
            n_eff = NW'(seq_len_reg);
        end

        if (motif_len_reg == '0) begin
            l_clamp = LW'(1);
        end else if (32'(motif_len_reg) > MAX_MOTIF) begin
            l_clamp = LW'(MAX_MOTIF);
        end else begin
            l_clamp = LW'(motif_len_reg);
        end

        // Every sequence must hold at least one full window.
        if (32'(l_clamp) > 32'(n_eff)) begin
            l_eff = LW'(n_eff);
        end else begin
            l_eff = l_clamp;
        end

        cap = CW'(t_eff) * CW'(n_eff);

        for (int k = 0; k < PW; k++) begin
            cand_mask[k] = (k < 2 * int'(l_eff));
        end
    end

    // ------------------------------------------------------------------
    // Base store
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == ST_LOAD);
    assign s_fire  = s_valid && s_ready;
    assign ram_we  = s_fire && (load_cnt_reg < cap);

    mss_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (load_cnt_reg[AW-1:0]),
        .wdata (s_data.base),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Search sequencer: walks the store once per candidate
    // ------------------------------------------------------------------
    always_comb begin
        issue_valid         = (state_reg == ST_SEARCH);
        issue_flags.win_ok  = (32'(pos_reg) + 32'd1 >= 32'(l_eff));
        issue_flags.seq_end = (pos_reg == n_eff - NW'(1));
        issue_flags.cand_end = (CW'(addr_reg) == cap - CW'(1));
        issue_flags.final_c = issue_flags.cand_end && (cand_reg == cand_mask);
    end

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        addr_next     = addr_reg;
        pos_next      = pos_reg;
        cand_next     = cand_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (load_cnt_reg < cap) begin
                        load_cnt_next = load_cnt_reg + CW'(1);
                    end
                    if (s_data.last) begin
                        load_cnt_next = '0;
                        addr_next     = '0;
                        pos_next      = '0;
                        cand_next     = '0;
                        state_next    = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (issue_flags.cand_end) begin
                    addr_next = '0;
                    pos_next  = '0;
                    cand_next = cand_reg + PW'(1);
                    if (issue_flags.final_c) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    addr_next = addr_reg + AW'(1);
                    pos_next  = issue_flags.seq_end ? '0 : pos_reg + NW'(1);
                end
            end
            ST_DRAIN: begin
                if (res_valid && res_final) begin
                    state_next = ST_PACK;
                end
            end
            ST_PACK: begin
                if (!m_valid || m_ready) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            addr_reg     <= '0;
            pos_reg      <= '0;
            cand_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            addr_reg     <= addr_next;
            pos_reg      <= pos_next;
            cand_reg     <= cand_next;
        end
    end

    mss_scorer #(
        .MAX_SEQS  (MAX_SEQS),
        .MAX_MOTIF (MAX_MOTIF)
    ) u_scorer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue_valid (issue_valid),
        .issue_flags (issue_flags),
        .issue_cand  (cand_reg),
        .cand_mask   (cand_mask),
        .base        (ram_rdata),
        .res_valid   (res_valid),
        .res_final   (res_final),
        .res_score   (res_score),
        .res_cand    (res_cand)
    );

    // ------------------------------------------------------------------
    // Best candidate; strict less-than keeps the first one found
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
        end else if (state_reg == ST_PACK) begin
            have_reg <= 1'b0;
        end else if (res_valid && (!have_reg || res_score < best_score_reg)) begin
            have_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && (!have_reg || res_score < best_score_reg)) begin
            best_score_reg <= res_score;
            best_motif_reg <= res_cand;
        end
    end

    // ------------------------------------------------------------------
    // Result: first motif position goes to the lowest bits
    // ------------------------------------------------------------------
    always_comb begin
        packed_motif = '0;
        for (int i = 0; i < MAX_MOTIF; i++) begin
            if (i < int'(l_eff)) begin
                packed_motif[2*i +: 2] = best_motif_reg[2*(int'(l_eff) - 1 - i) +: 2];
            end
        end
        if (32'(best_score_reg) > 32'(DIST_SAT)) begin
            dist_sat = DIST_SAT;
        end else begin
            dist_sat = 8'(best_score_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if ((state_reg == ST_PACK) && (!m_valid || m_ready)) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_PACK) && (!m_valid || m_ready)) begin
            m_data.motif         <= packed_motif[15:0];
            m_data.best_distance <= dist_sat;
        end
    end

endmodule

// ===== rtl/mss_ram.sv =====
// ----------------------------------------------------------------------------
// mss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mss_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/mss_scorer.sv =====
// ----------------------------------------------------------------------------
// mss_scorer
// Shared scoring unit: takes one base per cycle, keeps the sliding window,
// computes the Hamming distance to the candidate, tracks the per-sequence
// minimum and accumulates the candidate's total score.
// ----------------------------------------------------------------------------
module mss_scorer #(
    parameter int MAX_SEQS  = 16,
    parameter int MAX_MOTIF = 8
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         issue_valid,
    input  mss_pkg::step_flags_t                         issue_flags,
    input  logic [2*MAX_MOTIF-1:0]                       issue_cand,
    input  logic [2*MAX_MOTIF-1:0]                       cand_mask,
    input  logic [1:0]                                   base,
    output logic                                         res_valid,
    output logic                                         res_final,
    output logic [$clog2(MAX_SEQS*MAX_MOTIF+1)-1:0]      res_score,
    output logic [2*MAX_MOTIF-1:0]                       res_cand
);

    import mss_pkg::*;

    localparam int PW = 2 * MAX_MOTIF;
    localparam int LW = $clog2(MAX_MOTIF + 1);
    localparam int SW = $clog2(MAX_SEQS * MAX_MOTIF + 1);

    logic              stg_valid_reg;
    step_flags_t       stg_flags_reg;
    logic [PW-1:0]     stg_cand_reg;

    logic [PW-1:0]     win_reg, win_next;
    logic [LW-1:0]     mind_reg, mind_next;
    logic [SW-1:0]     sum_reg, sum_next;
    logic [PW-1:0]     diff;
    logic [LW-1:0]     win_dist;
    logic [LW-1:0]     mind_upd;
    logic [SW-1:0]     total;

    always_comb begin
        win_next = ((win_reg << 2) | PW'(base)) & cand_mask;
        diff     = win_next ^ stg_cand_reg;
        win_dist = '0;
        for (int i = 0; i < MAX_MOTIF; i++) begin
            win_dist = win_dist + LW'(diff[2*i] | diff[2*i+1]);
        end
        mind_upd = mind_reg;
        if (stg_flags_reg.win_ok && (win_dist < mind_reg)) begin
            mind_upd = win_dist;
        end
        total     = sum_reg + SW'(mind_upd);
        mind_next = mind_upd;
        sum_next  = sum_reg;
        if (stg_flags_reg.seq_end) begin
            mind_next = '1;
            sum_next  = stg_flags_reg.cand_end ? '0 : total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
            res_valid     <= 1'b0;
            mind_reg      <= '1;
            sum_reg       <= '0;
        end else begin
            stg_valid_reg <= issue_valid;
            res_valid     <= stg_valid_reg && stg_flags_reg.cand_end;
            if (stg_valid_reg) begin
                mind_reg <= mind_next;
                sum_reg  <= sum_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        stg_flags_reg <= issue_flags;
        stg_cand_reg  <= issue_cand;
        if (stg_valid_reg) begin
            win_reg   <= win_next;
            res_score <= total;
            res_cand  <= stg_cand_reg;
            res_final <= stg_flags_reg.final_c;
        end
    end

endmodule

// ===== tb/sv/tb_median_string_search_unit.sv =====
// ----------------------------------------------------------------------------
// tb_median_string_search_unit
// Self-checking bench for the median string search unit. Data sets are
// streamed in one base per item; each returned motif and distance is checked
// against a directed row's given value, else against a brute-force search on
// the bench's own copy of the base store and registers. A directed table comes
// first, then register extremes, then random data sets with random idling.
// ----------------------------------------------------------------------------
module tb_median_string_search_unit;
    import mss_pkg::*;

    localparam int MAX_SEQS      = 16;
    localparam int MAX_LEN       = 256;
    localparam int MAX_MOTIF     = 8;
    localparam int STORE_DEPTH   = MAX_SEQS * MAX_LEN;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 5000;
    // The slowest search is motif length 8 over 8 bases.
    localparam int IDLE_LIMIT    = 2_000_000;
    localparam int DIR_ROWS      = 20;

    typedef struct packed {
        logic [4:0]  ns;
        logic [8:0]  sl;
        logic [3:0]  ml;
        logic [1:0]  base;
        logic        last;
        logic        typed;
        logic [15:0] want_motif;
        logic [7:0]  want_dist;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Shadow copy of the block's registers and base store.
    logic [4:0]  cfg_seqs;
    logic [8:0]  cfg_len;
    logic [3:0]  cfg_motif;
    logic [1:0]  dna [STORE_DEPTH];
    int          load_idx;
    int          written_upto;

    out_t        motif_q [$];
    logic [1:0]  set_bases [STORE_DEPTH + 4];
    int          errors;
    int          set_items;
    int          idle_cycles;
    int          hold_req;
    bit          gaps_on;

    // Directed data sets, one item per row. Rows of a set share one setting.
    dir_row_t dir_rows [DIR_ROWS] = '{
        // single base, smallest setting
        '{5'd1, 9'd1, 4'd1, 2'd3, 1'b1, 1'b1, 16'h0003, 8'd0},
        // motif length 4: the sequence itself wins, first base in the low bits
        '{5'd1, 9'd4, 4'd4, 2'd0, 1'b0, 1'b0, 16'h0000, 8'd0},
        '{5'd1, 9'd4, 4'd4, 2'd1, 1'b0, 1'b0, 16'h0000, 8'd0},
        '{5'd1, 9'd4, 4'd4, 2'd2, 1'b0, 1'b0, 16'h0000, 8'd0},
        '{5'd1, 9'd4, 4'd4, 2'd3, 1'b1, 1'b1, 16'h00E4, 8'd0},
        // one item too many: the third base is dropped
        '{5'd1, 9'd2, 4'd1, 2'd3, 1'b0, 1'b0, 16'h0000, 8'd0},
        '{5'd1, 9'd2, 4'd1, 2'd3, 1'b0, 1'b0, 16'h0000, 8'd0},
        '{5'd1, 9'd2, 4'd1, 2'd0, 1'b1, 1'b1, 16'h0003, 8'd0},
        // too few items: the old second base is still in the store
        '{5'd1, 9'd2, 4'd1, 2'd0, 1'b1, 1'b1, 16'h0000, 8'd0},
        // tie between c and g: the first one stays
        '{5'd1, 9'd2, 4'd1, 2'd2, 1'b0, 1'b0, 16'h0000, 8'd0},
        '{5'd1, 9'd2, 4'd1, 2'd1, 1'b1, 1'b1, 16'h0001, 8'd0},
        // two one-base sequences that disagree
        '{5'd2, 9'd1, 4'd1, 2'd0, 1'b0, 1'b0, 16'h0000, 8'd0},
        '{5'd2, 9'd1, 4'd1, 2'd3, 1'b1, 1'b1, 16'h0000, 8'd1},
        // three sequences of two bases with a tie at the best score
        '{5'd3, 9'd2, 4'd2, 2'd0, 1'b0, 1'b0, 16'h0000, 8'd0},
        '{5'd3, 9'd2, 4'd2, 2'd1, 1'b0, 1'b0, 16'h0000, 8'd0},
        '{5'd3, 9'd2, 4'd2, 2'd1, 1'b0, 1'b0, 16'h0000, 8'd0},
        '{5'd3, 9'd2, 4'd2, 2'd1, 1'b0, 1'b0, 16'h0000, 8'd0},
        '{5'd3, 9'd2, 4'd2, 2'd3, 1'b0, 1'b0, 16'h0000, 8'd0},
        '{5'd3, 9'd2, 4'd2, 2'd1, 1'b1, 1'b0, 16'h0000, 8'd0},
        // all registers zero, each clamped up to one
        '{5'd0, 9'd0, 4'd0, 2'd2, 1'b1, 1'b1, 16'h0002, 8'd0}
    };

    median_string_search_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Effective sequence count, sequence length and motif length.
    function automatic void eff_dims(output int t, output int n, output int l);
        t = (cfg_seqs < 1) ? 1 : (cfg_seqs > MAX_SEQS) ? MAX_SEQS : int'(cfg_seqs);
        n = (cfg_len < 1) ? 1 : (cfg_len > MAX_LEN) ? MAX_LEN : int'(cfg_len);
        l = (cfg_motif < 1) ? 1 : (cfg_motif > MAX_MOTIF) ? MAX_MOTIF : int'(cfg_motif);
        if (l > n) l = n;
    endfunction

    // Tries every candidate, first position as the most significant digit,
    // and keeps the first one with the lowest summed window distance.
    function automatic out_t find_median();
        int   t, n, l, total, mask, cand, best, best_cand;
        int   score, s, j, i, win, x, d, mind;
        out_t r;
        eff_dims(t, n, l);
        mask = (1 << (2 * l)) - 1;
        total = 1 << (2 * l);
        best = 0;
        best_cand = 0;
        for (cand = 0; cand < total; cand++) begin
            score = 0;
            for (s = 0; s < t; s++) begin
                win = 0;
                mind = 1 << 30;
                for (j = 0; j < n; j++) begin
                    win = ((win << 2) | int'(dna[s * n + j])) & mask;
                    if (j + 1 >= l) begin
                        x = win ^ cand;
                        d = 0;
                        for (i = 0; i < l; i++) begin
                            if (((x >> (2 * i)) & 3) != 0) d++;
                        end
                        if (d < mind) mind = d;
                    end
                end
                score += mind;
            end
            if (cand == 0 || score < best) begin
                best = score;
                best_cand = cand;
            end
        end
        r = '0;
        r.best_distance = (best > 255) ? DIST_SAT : best[7:0];
        for (i = 0; i < l; i++) begin
            r.motif[2 * i +: 2] = 2'((best_cand >> (2 * (l - 1 - i))) & 3);
        end
        return r;
    endfunction

    // Stores one base; returns 1 with the result when the item ends a data set.
    function automatic bit take_base(in_t it, output out_t res);
        int t, n, l;
        eff_dims(t, n, l);
        res = '0;
        if (load_idx < t * n) begin
            dna[load_idx] = it.base;
            load_idx++;
            if (load_idx > written_upto) written_upto = load_idx;
        end
        if (!it.last) return 1'b0;
        res = find_median();
        load_idx = 0;
        return 1'b1;
    endfunction

    task automatic apb_access(bit wr, logic [1:0] idx, logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_register(logic [1:0] idx, logic [31:0] want, int width);
        logic [31:0] rd;
        logic [31:0] mask;
        mask = (32'd1 << width) - 1;
        apb_access(1'b0, idx, '0, rd);
        if ((rd & mask) != want)
            report_mismatch($sformatf("register %0d reads %0d, expected %0d",
                                      idx, rd & mask, want));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value, int width);
        logic [31:0] rd;
        logic [31:0] mask;
        mask = (32'd1 << width) - 1;
        // Bits above the register width carry junk and must be ignored.
        apb_access(1'b1, idx, ($urandom & ~mask) | value, rd);
        check_register(idx, value, width);
    endtask

    // Stops offering items and waits until every result has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (motif_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(logic [4:0] ns, logic [8:0] sl, logic [3:0] ml);
        wait_drained();
        write_reg(REG_NUM_SEQS, 32'(ns), 5);
        write_reg(REG_SEQ_LEN, 32'(sl), 9);
        write_reg(REG_MOTIF_LEN, 32'(ml), 4);
        cfg_seqs  = ns;
        cfg_len   = sl;
        cfg_motif = ml;
    endtask

    task automatic send_item(in_t it, bit typed, out_t want);
        int   gap;
        out_t res;
        gap = pick_gap(gaps_on);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        if (take_base(it, res)) motif_q.push_back(typed ? want : res);
    endtask

    // Sends one data set. A shaped set may be short (only when the store is
    // already written that far) or carry a few surplus items.
    task automatic run_set(bit shaped);
        int         t, n, l, cap, k, r, s, p, i;
        logic [1:0] mot [MAX_MOTIF];
        in_t        it;
        eff_dims(t, n, l);
        cap = t * n;
        k = cap;
        if (shaped) begin
            r = $urandom_range(0, 99);
            if (r < 15 && cap > 1 && written_upto >= cap) k = $urandom_range(1, cap - 1);
            else if (r < 30) k = cap + $urandom_range(1, 3);
        end
        for (i = 0; i < k; i++) set_bases[i] = 2'($urandom_range(0, 3));
        // Often plant a noisy copy of one motif in every sequence.
        if ($urandom_range(0, 1) == 1) begin
            for (i = 0; i < l; i++) mot[i] = 2'($urandom_range(0, 3));
            for (s = 0; s < t; s++) begin
                p = $urandom_range(0, n - l);
                for (i = 0; i < l; i++) begin
                    if ($urandom_range(0, 4) != 0) set_bases[s * n + p + i] = mot[i];
                end
            end
        end
        gaps_on = ($urandom_range(0, 3) != 0);
        for (i = 0; i < k; i++) begin
            it.base = set_bases[i];
            it.last = (i == k - 1);
            send_item(it, 1'b0, '0);
        end
        set_items += (k < cap) ? k : cap;
    endtask

    // Mostly small settings so that a search stays short.
    task automatic pick_config(output logic [4:0] ns, output logic [8:0] sl,
                               output logic [3:0] ml);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            ns = 5'($urandom_range(1, 4));
            sl = 9'($urandom_range(1, 12));
            ml = 4'($urandom_range(1, (sl < 3) ? int'(sl) : 3));
        end else if (r < 80) begin
            ns = 5'($urandom_range(1, 2));
            sl = 9'($urandom_range(4, 6));
            ml = 4'd4;
        end else if (r < 88) begin
            ns = ($urandom_range(0, 1) == 1) ? 5'd0 : 5'($urandom_range(17, 31));
            sl = 9'($urandom_range(1, 3));
            ml = 4'($urandom_range(1, 2));
        end else if (r < 94) begin
            ns = 5'($urandom_range(1, 4));
            sl = 9'($urandom_range(1, 3));
            ml = ($urandom_range(0, 1) == 1) ? 4'd0 : 4'($urandom_range(9, 15));
        end else begin
            ns = 5'd1;
            sl = ($urandom_range(0, 1) == 1) ? 9'd0 : 9'($urandom_range(257, 511));
            ml = 4'($urandom_range(1, 2));
        end
    endtask

    // Result checker.
    always @(posedge aclk) begin : check_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (motif_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result motif=%h distance=%0d",
                                          m_data.motif, m_data.best_distance));
            end else begin
                want = motif_q.pop_front();
                if (m_data.motif != want.motif)
                    report_mismatch($sformatf("motif %h, expected %h",
                                              m_data.motif, want.motif));
                if (m_data.best_distance != want.best_distance)
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              m_data.best_distance, want.best_distance));
            end
        end
    end

    // Watchdog on cycles without any accepted item or register access.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result receiver: random stalls, ready stretches, and one long hold.
    initial begin : receiver
        int n;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req > 0) begin
                n = hold_req;
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            n = pick_gap($urandom_range(0, 3) != 0);
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 150 : 6)) @(posedge aclk);
        end
    end

    initial begin : stimulus
        logic [4:0] ns;
        logic [8:0] sl;
        logic [3:0] ml;
        int         r, t, n, l, n_sets, group_no;
        in_t        it;
        out_t       want;

        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        errors = 0;
        set_items = 0;
        idle_cycles = 0;
        hold_req = 0;
        gaps_on = 1'b1;
        load_idx = 0;
        written_upto = 0;
        cfg_seqs  = NUM_SEQS_RST;
        cfg_len   = SEQ_LEN_RST;
        cfg_motif = MOTIF_LEN_RST;
        for (r = 0; r < STORE_DEPTH; r++) dna[r] = 2'd0;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_register(REG_NUM_SEQS, 32'(NUM_SEQS_RST), 5);
        check_register(REG_SEQ_LEN, 32'(SEQ_LEN_RST), 9);
        check_register(REG_MOTIF_LEN, 32'(MOTIF_LEN_RST), 4);

        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].ns != cfg_seqs || dir_rows[r].sl != cfg_len ||
                dir_rows[r].ml != cfg_motif)
                set_config(dir_rows[r].ns, dir_rows[r].sl, dir_rows[r].ml);
            it.base = dir_rows[r].base;
            it.last = dir_rows[r].last;
            want.motif = dir_rows[r].want_motif;
            want.best_distance = dir_rows[r].want_dist;
            send_item(it, dir_rows[r].typed, want);
        end

        // Register extremes, each with one full data set.
        set_config(5'd1, 9'd8, 4'd8);
        run_set(1'b0);
        set_config(5'd16, 9'd1, 4'd1);
        run_set(1'b0);
        set_config(5'd1, 9'd256, 4'd1);
        run_set(1'b0);
        set_config(5'd31, 9'd1, 4'd15);
        run_set(1'b0);
        set_config(5'd1, 9'd511, 4'd1);
        run_set(1'b0);

        // The random sets top up the item count left by the sets above.
        group_no = 0;
        while (set_items < RANDOM_ITEMS) begin
            if (group_no == 2) begin
                // The first result is held, so the next sets back up the input.
                set_config(5'd2, 9'd6, 4'd2);
                hold_req = LONG_HOLD;
                wait (hold_req == 0);
                n_sets = 3;
            end else begin
                pick_config(ns, sl, ml);
                set_config(ns, sl, ml);
                eff_dims(t, n, l);
                n_sets = (t * n > 64) ? 1 : $urandom_range(1, 3);
            end
            repeat (n_sets) run_set(1'b1);
            group_no++;
        end

        wait_drained();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
